// ===== design/mpsm_pkg.sv =====
// Shared types and constants of the multi-pattern string matcher.
// Used by mpsm_ctrl, mpsm_dp and the top level; depends on nothing else.
`default_nettype none

package mpsm_pkg;

   localparam int DEF_ALPHABET  = 26;
   localparam int DEF_MAX_NODES = 256;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int SYM_W      = 5;
   localparam int NODE_W     = 8;

   // Phase of a work frame.
   localparam logic [1:0] PH_ENTER = 2'd0;
   localparam logic [1:0] PH_CALL  = 2'd1;
   localparam logic [1:0] PH_STORE = 2'd2;

   typedef enum logic {
      FR_LINK = 1'b0,
      FR_GO   = 1'b1
   } frame_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_SCAN,
      ST_EVAL,
      ST_GO_CHK,
      ST_LINK_CHK,
      ST_LETTER,
      ST_POP_RD,
      ST_FIN_RD,
      ST_FIN,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_INS_READ,
      OP_INS_COMMIT,
      OP_SCAN_START,
      OP_FRAME_READ,
      OP_GO_HIT,
      OP_GO_CHILD,
      OP_GO_ROOT,
      OP_GO_STORE,
      OP_LINK_HIT,
      OP_LINK_ROOT,
      OP_LINK_STORE,
      OP_PUSH_SELF_LINK,
      OP_PUSH_PARENT_LINK,
      OP_PUSH_GO_RET,
      OP_PUSH_GO_LETTER,
      OP_POP_LOAD,
      OP_FIN_READ,
      OP_FIN,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic           req_opcode;
      logic           sym_ok;
      frame_kind_type kind;
      logic [1:0]     phase;
      logic           goto_hit;
      logic           child_hit;
      logic           link_hit;
      logic           v_zero;
      logic           parent_zero;
      logic           depth_one;
      logic           stack_full;
      logic           clear_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/mpsm_dp.sv =====
// Datapath of the matcher: trie and memo tables, work stack, cursors, result register.
// Depends on mpsm_pkg; driven by mpsm_ctrl through dp_op_type commands.
`default_nettype none

module mpsm_dp #(
   parameter int ALPHABET  = mpsm_pkg::DEF_ALPHABET,
   parameter int MAX_NODES = mpsm_pkg::DEF_MAX_NODES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [mpsm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tuser,
   input  wire mpsm_pkg::dp_op_type             cmd,
   output      mpsm_pkg::dp_status_type         status,
   output      logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mpsm_pkg::*;

   localparam int NW          = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LW          = $clog2(MAX_NODES + 1);
   localparam int SW          = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int TABLE       = MAX_NODES * ALPHABET;
   localparam int AW          = $clog2(TABLE);
   localparam int STACK_DEPTH = MAX_NODES + 4;
   localparam int SMW         = $clog2(STACK_DEPTH - 1);
   localparam int DW          = $clog2(STACK_DEPTH + 1);
   localparam logic [LW-1:0] NO_NODE = LW'(MAX_NODES);

   typedef struct packed {
      frame_kind_type kind;
      logic [NW-1:0]  v;
      logic [SW-1:0]  c;
      logic [1:0]     phase;
   } frame_type;

   // Storage.
   logic [LW-1:0] child_mem  [TABLE];
   logic [LW-1:0] goto_mem   [TABLE];
   logic [LW-1:0] link_mem   [MAX_NODES];
   logic [NW-1:0] parent_mem [MAX_NODES];
   logic [SW-1:0] letter_mem [MAX_NODES];
   logic          ends_mem   [MAX_NODES];
   frame_type     stack_mem  [STACK_DEPTH-1];

   // Item and control registers.
   logic          last_ff, restart_ff;
   logic [SYM_W-1:0] sym_ff;
   logic [NW-1:0] ins_cur_ff, ins_cur_in;
   logic [NW-1:0] scan_cur_ff, scan_cur_in;
   logic [LW-1:0] node_cnt_ff, node_cnt_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0] ret_ff, ret_in;
   frame_type     top_ff, top_in;
   logic          res_match_ff, res_status_ff;
   logic [NW-1:0] res_node_ff;
   logic          rsp_match_ff, rsp_status_ff;
   logic [NODE_W-1:0] rsp_node_ff;

   // Registered read data.
   logic [LW-1:0] child_rd_ff, goto_rd_ff, link_rd_ff;
   logic [NW-1:0] parent_rd_ff;
   logic [SW-1:0] letter_rd_ff;
   logic          ends_rd_ff;
   frame_type     stack_rd_ff;

   logic          sym_ok;
   logic [SW-1:0] sym_c;
   logic [AW-1:0] ins_slot, top_slot, child_raddr;
   logic          ins_hit, ins_create, ins_ok;
   logic [NW-1:0] ins_v;
   logic          is_push, is_pop, stack_full;
   frame_type     new_frame, saved_frame;
   logic          clr_node;

   logic          child_we, goto_we, link_we, ends_we, node_we, stack_we;
   logic [AW-1:0] child_waddr;
   logic [LW-1:0] child_wdata, goto_wdata, link_wdata;
   logic [NW-1:0] link_waddr, ends_waddr;
   logic          ends_wdata;

   assign sym_ok      = 32'(sym_ff) < 32'(ALPHABET);
   assign sym_c       = SW'(sym_ff);
   assign ins_slot    = AW'(ins_cur_ff) * AW'(ALPHABET) + AW'(sym_c);
   assign top_slot    = AW'(top_ff.v) * AW'(ALPHABET) + AW'(top_ff.c);
   assign child_raddr = (cmd == OP_INS_READ) ? ins_slot : top_slot;
   assign stack_full  = 32'(depth_ff) >= 32'(STACK_DEPTH);
   assign clr_node    = 32'(clr_cnt_ff) < 32'(MAX_NODES);

   assign ins_hit    = sym_ok && (child_rd_ff != NO_NODE);
   assign ins_create = sym_ok && !ins_hit && (32'(node_cnt_ff) < 32'(MAX_NODES));
   assign ins_ok     = ins_hit || ins_create;
   always_comb begin
      if (ins_hit) begin
         ins_v = NW'(child_rd_ff);
      end else if (ins_create) begin
         ins_v = NW'(node_cnt_ff);
      end else begin
         ins_v = ins_cur_ff;
      end
   end

   assign is_push = (cmd == OP_PUSH_SELF_LINK) || (cmd == OP_PUSH_PARENT_LINK) ||
                    (cmd == OP_PUSH_GO_RET) || (cmd == OP_PUSH_GO_LETTER);
   assign is_pop  = (cmd == OP_GO_HIT) || (cmd == OP_GO_CHILD) || (cmd == OP_GO_ROOT) ||
                    (cmd == OP_GO_STORE) || (cmd == OP_LINK_HIT) ||
                    (cmd == OP_LINK_ROOT) || (cmd == OP_LINK_STORE);

   // The frame left below the new one resumes at its next phase.
   always_comb begin
      saved_frame       = top_ff;
      saved_frame.phase = top_ff.phase + 2'd1;
      new_frame         = '{kind: FR_LINK, v: top_ff.v, c: '0, phase: PH_ENTER};
      case (cmd)
         OP_PUSH_PARENT_LINK: new_frame.v = parent_rd_ff;
         OP_PUSH_GO_RET: begin
            new_frame.kind = FR_GO;
            new_frame.v    = ret_ff;
            new_frame.c    = top_ff.c;
         end
         OP_PUSH_GO_LETTER: begin
            new_frame.kind = FR_GO;
            new_frame.v    = ret_ff;
            new_frame.c    = letter_rd_ff;
         end
         default: new_frame.v = top_ff.v;
      endcase
   end

   // Write port selection.
   always_comb begin
      child_we    = 1'b0;
      child_waddr = ins_slot;
      child_wdata = LW'(node_cnt_ff);
      goto_we     = 1'b0;
      goto_wdata  = LW'(ret_ff);
      link_we     = 1'b0;
      link_waddr  = top_ff.v;
      link_wdata  = LW'(ret_ff);
      ends_we     = 1'b0;
      ends_waddr  = ins_v;
      ends_wdata  = 1'b1;
      node_we     = 1'b0;
      stack_we    = 1'b0;
      case (cmd)
         OP_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clr_cnt_ff;
            child_wdata = NO_NODE;
            goto_we     = 1'b1;
            goto_wdata  = NO_NODE;
            link_we     = clr_node;
            link_waddr  = NW'(clr_cnt_ff);
            link_wdata  = NO_NODE;
            ends_we     = clr_node;
            ends_waddr  = NW'(clr_cnt_ff);
            ends_wdata  = 1'b0;
         end
         OP_INS_COMMIT: begin
            child_we = ins_create;
            node_we  = ins_create;
            ends_we  = ins_ok && last_ff;
         end
         OP_GO_CHILD: begin
            goto_we    = 1'b1;
            goto_wdata = child_rd_ff;
         end
         OP_GO_ROOT: begin
            goto_we    = 1'b1;
            goto_wdata = '0;
         end
         OP_GO_STORE:   goto_we = 1'b1;
         OP_LINK_ROOT: begin
            link_we    = 1'b1;
            link_wdata = '0;
         end
         OP_LINK_STORE: link_we = 1'b1;
         default:       stack_we = is_push && !stack_full;
      endcase
   end

   // Memories: one write port, registered read.
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      child_rd_ff <= child_mem[child_raddr];
   end

   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem[child_waddr == ins_slot && cmd == OP_CLEAR ? clr_cnt_ff :
                  (cmd == OP_CLEAR ? clr_cnt_ff : top_slot)] <= goto_wdata;
      end
      goto_rd_ff <= goto_mem[top_slot];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[top_ff.v];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         parent_mem[NW'(node_cnt_ff)] <= ins_cur_ff;
         letter_mem[NW'(node_cnt_ff)] <= sym_c;
      end
      parent_rd_ff <= parent_mem[top_ff.v];
      letter_rd_ff <= letter_mem[top_ff.v];
   end

   always_ff @(posedge clock) begin
      if (ends_we) begin
         ends_mem[ends_waddr] <= ends_wdata;
      end
      ends_rd_ff <= ends_mem[ret_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[SMW'(depth_ff - DW'(1))] <= saved_frame;
      end
      stack_rd_ff <= stack_mem[SMW'(depth_ff - DW'(2))];
   end

   // Cursors, counters and the resolution registers.
   always_comb begin
      ins_cur_in  = ins_cur_ff;
      scan_cur_in = scan_cur_ff;
      node_cnt_in = node_cnt_ff;
      depth_in    = depth_ff;
      clr_cnt_in  = clr_cnt_ff;
      ret_in      = ret_ff;
      top_in      = top_ff;
      if (is_pop) begin
         depth_in = depth_ff - DW'(1);
      end
      if (is_push) begin
         if (stack_full) begin
            ret_in = '0;
         end else begin
            top_in   = new_frame;
            depth_in = depth_ff + DW'(1);
         end
      end
      case (cmd)
         OP_CLEAR: clr_cnt_in = clr_cnt_ff + AW'(1);
         OP_INS_COMMIT: begin
            ins_cur_in = last_ff ? '0 : ins_v;
            if (ins_create) begin
               node_cnt_in = node_cnt_ff + LW'(1);
            end
         end
         OP_SCAN_START: begin
            if (sym_ok) begin
               top_in   = '{kind: FR_GO, v: (restart_ff ? '0 : scan_cur_ff),
                            c: sym_c, phase: PH_ENTER};
               depth_in = DW'(1);
            end else begin
               scan_cur_in = '0;
            end
         end
         OP_GO_HIT:    ret_in = NW'(goto_rd_ff);
         OP_GO_CHILD:  ret_in = NW'(child_rd_ff);
         OP_GO_ROOT:   ret_in = '0;
         OP_LINK_HIT:  ret_in = NW'(link_rd_ff);
         OP_LINK_ROOT: ret_in = '0;
         OP_POP_LOAD:  top_in = stack_rd_ff;
         OP_FIN_READ:  scan_cur_in = ret_ff;
         default:      ret_in = ret_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_cur_ff  <= '0;
         scan_cur_ff <= '0;
         node_cnt_ff <= LW'(1);
         depth_ff    <= '0;
         clr_cnt_ff  <= '0;
      end else begin
         ins_cur_ff  <= ins_cur_in;
         scan_cur_ff <= scan_cur_in;
         node_cnt_ff <= node_cnt_in;
         depth_ff    <= depth_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      top_ff <= top_in;
      if (cmd == OP_LOAD) begin
         sym_ff     <= req_tdata[SYM_W:1];
         last_ff    <= req_tlast;
         restart_ff <= req_tuser;
      end
      case (cmd)
         OP_INS_COMMIT: begin
            res_match_ff  <= 1'b0;
            res_node_ff   <= ins_v;
            res_status_ff <= !ins_ok;
         end
         OP_SCAN_START: begin
            res_match_ff  <= 1'b0;
            res_node_ff   <= '0;
            res_status_ff <= 1'b0;
         end
         OP_FIN: begin
            res_match_ff  <= ends_rd_ff;
            res_node_ff   <= scan_cur_ff;
            res_status_ff <= 1'b0;
         end
         OP_EMIT: begin
            rsp_match_ff  <= res_match_ff;
            rsp_node_ff   <= NODE_W'(res_node_ff);
            rsp_status_ff <= res_status_ff;
         end
         default: res_match_ff <= res_match_ff;
      endcase
   end

   assign rsp_tdata = {{(RSP_DATA_W - NODE_W - 2){1'b0}}, rsp_status_ff, rsp_node_ff,
                       rsp_match_ff};

   always_comb begin
      status.req_opcode  = req_tdata[0];
      status.sym_ok      = sym_ok;
      status.kind        = top_ff.kind;
      status.phase       = top_ff.phase;
      status.goto_hit    = goto_rd_ff != NO_NODE;
      status.child_hit   = child_rd_ff != NO_NODE;
      status.link_hit    = link_rd_ff != NO_NODE;
      status.v_zero      = top_ff.v == '0;
      status.parent_zero = parent_rd_ff == '0;
      status.depth_one   = depth_ff == DW'(1);
      status.stack_full  = stack_full;
      status.clear_done  = clr_cnt_ff == AW'(TABLE - 1);
   end

   // Invariants of the trie and the work stack.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(depth_ff) <= 32'(STACK_DEPTH))
      else $error("work stack depth beyond its size");
   a_ins_cur_valid: assert property (@(posedge clock) disable iff (reset)
      LW'(ins_cur_ff) < node_cnt_ff)
      else $error("insert cursor points at an unallocated node");
   a_scan_cur_valid: assert property (@(posedge clock) disable iff (reset)
      LW'(scan_cur_ff) < node_cnt_ff)
      else $error("scan cursor points at an unallocated node");

endmodule

`default_nettype wire

// ===== design/mpsm_ctrl.sv =====
// Controller state machine of the matcher: sequences inserts, scans and link resolution.
// Depends on mpsm_pkg; commands mpsm_dp and owns the result valid flag.
`default_nettype none

module mpsm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire mpsm_pkg::dp_status_type status,
   output      mpsm_pkg::dp_op_type     cmd
);
   import mpsm_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           emit_load;
   ctrl_state_type after_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign after_pop = status.depth_one ? ST_FIN_RD : ST_POP_RD;

   always_comb begin
      state_in   = state_ff;
      cmd        = OP_NONE;
      req_tready = 1'b0;
      emit_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd = OP_CLEAR;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = OP_LOAD;
               state_in = status.req_opcode ? ST_SCAN : ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            cmd      = OP_INS_READ;
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            cmd      = OP_INS_COMMIT;
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            cmd      = OP_SCAN_START;
            state_in = status.sym_ok ? ST_EVAL : ST_EMIT;
         end
         ST_EVAL: begin
            if (status.phase == PH_ENTER) begin
               cmd      = OP_FRAME_READ;
               state_in = (status.kind == FR_GO) ? ST_GO_CHK : ST_LINK_CHK;
            end else if (status.phase == PH_CALL) begin
               if (status.kind == FR_GO) begin
                  cmd      = OP_PUSH_GO_RET;
                  state_in = status.stack_full ? ST_FIN_RD : ST_EVAL;
               end else begin
                  cmd      = OP_FRAME_READ;
                  state_in = ST_LETTER;
               end
            end else begin
               cmd      = (status.kind == FR_GO) ? OP_GO_STORE : OP_LINK_STORE;
               state_in = after_pop;
            end
         end
         ST_GO_CHK: begin
            if (status.goto_hit) begin
               cmd      = OP_GO_HIT;
               state_in = after_pop;
            end else if (status.child_hit) begin
               cmd      = OP_GO_CHILD;
               state_in = after_pop;
            end else if (status.v_zero) begin
               cmd      = OP_GO_ROOT;
               state_in = after_pop;
            end else begin
               cmd      = OP_PUSH_SELF_LINK;
               state_in = status.stack_full ? ST_FIN_RD : ST_EVAL;
            end
         end
         ST_LINK_CHK: begin
            if (status.link_hit) begin
               cmd      = OP_LINK_HIT;
               state_in = after_pop;
            end else if (status.v_zero || status.parent_zero) begin
               cmd      = OP_LINK_ROOT;
               state_in = after_pop;
            end else begin
               cmd      = OP_PUSH_PARENT_LINK;
               state_in = status.stack_full ? ST_FIN_RD : ST_EVAL;
            end
         end
         ST_LETTER: begin
            cmd      = OP_PUSH_GO_LETTER;
            state_in = status.stack_full ? ST_FIN_RD : ST_EVAL;
         end
         ST_POP_RD: begin
            cmd      = OP_POP_LOAD;
            state_in = ST_EVAL;
         end
         ST_FIN_RD: begin
            cmd      = OP_FIN_READ;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd      = OP_FIN;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd       = OP_EMIT;
               emit_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A result cannot appear immediately after its transaction is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result raised right after acceptance");
   // The output register is only reloaded when its previous result has left.
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");
   // Input is never taken during the clearing pass.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !(req_tready && $past(state_ff) == ST_CLEAR &&
                                   state_ff == ST_CLEAR))
      else $error("input accepted while tables are being cleared");

endmodule

`default_nettype wire

// ===== design/multi_pattern_string_matcher_core.sv =====
// Top level of the multi-pattern string matcher (Aho-Corasick automaton with lazy goto).
// Depends on mpsm_pkg, mpsm_ctrl and mpsm_dp.
//
//   Channel | Direction | Transaction carries
//   req_    | in        | tdata[0] opcode, tdata[5:1] symbol, tlast last, tuser restart
//   rsp_    | out       | tdata[0] match, tdata[8:1] node, tdata[9] status
//
// An insert transaction passes through ST_INS_RD, ST_INS_WR and ST_EMIT from acceptance to a
// valid result, and the next transaction can be accepted in ST_IDLE after that.
// A scan whose transition is already memoized is the shortest case; every frame of
// suffix-link resolution adds more states to it, so scan time depends on the text.
// After reset a clearing pass over all MAX_NODES * ALPHABET entries (6656 by default)
// empties the trie and memo tables; req_tready stays low during it.
// A waiting result does not block acceptance; a finished item only waits for the output
// register to be taken before it is loaded.
`default_nettype none

module multi_pattern_string_matcher_core #(
   parameter int ALPHABET  = mpsm_pkg::DEF_ALPHABET,
   parameter int MAX_NODES = mpsm_pkg::DEF_MAX_NODES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // Fields from bit 0: opcode, symbol[4:0], two zero pad bits.
   input  wire logic [mpsm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,
   // Fields from bit 0: restart.
   input  wire logic                            req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // Fields from bit 0: match, node[7:0], status, six zero pad bits.
   output      logic [mpsm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mpsm_pkg::*;

   // The controller sees the datapath only through the status bundle and issues one datapath command a cycle.
   dp_op_type     cmd;
   dp_status_type status;

   mpsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the tables, the work stack and the result registers.
   mpsm_dp #(
      .ALPHABET  (ALPHABET),
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
